/* hdl/b64d_pkg.sv */
// shared types and constants for the base64 stream decoder
package b64d_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   localparam int unsigned ACC_WIDTH   = 24;
   localparam int unsigned COUNT_WIDTH = 5;
   localparam logic [COUNT_WIDTH-1:0] MAX_BITS = 5'd24;

   typedef enum logic [1:0] {
      CLS_DATA = 2'b00,
      CLS_PAD  = 2'b01,
      CLS_BAD  = 2'b10
   } char_class_type;

   // one closed group, queued between front and back
   typedef struct packed {
      logic [ACC_WIDTH-1:0]   acc;
      logic [COUNT_WIDTH-1:0] bit_count;
      logic                   last;
      logic                   bad;
   } group_type;

endpackage

/* hdl/base64_stream_decoder_top.sv */
// top level of the base64 stream decoder: front, group queue and back
// path: with an idle back end, a run's accepted closing request writes the queue, then its
// group loads the output register as the run's first result; the queue absorbs bursts of
// closed groups; throughput: one request a cycle while the queue has room, one result a cycle
// while rsp_ready is high; a run gives one result per byte, or one empty result if it has none
// reset: synchronous, active high; clears the open group, the queue and the output valid flag
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   // request channel: one character per request
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   // result channel: one byte slot per result
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_stream_end,
   output logic       rsp_bad_char
);

   // closed groups travel from front to back as one record
   group_type push_data;
   group_type head;
   logic      push;
   logic      pop;
   logic      q_full;
   logic      q_empty;

   // front: classify, pack sextets, close a group on its fourth data or pad char or on last
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_char (req_in_char),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   // queue decouples character intake from byte output
   b64d_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: emit whole bytes of the head group, most significant first
   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end),
      .rsp_bad_char   (rsp_bad_char)
   );

endmodule

/* hdl/b64d_front.sv */
// front end: classifies characters and packs sextets into closed groups
module b64d_front
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   input  logic       q_full,
   output logic       push,
   output group_type  push_data
);

   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] bits_ff, bits_in;
   logic [1:0]             chars_ff, chars_in;
   logic                   bad_ff, bad_in;
   char_class_type         cls;
   logic [5:0]             sextet;
   logic [COUNT_WIDTH:0]   bits_sum;
   logic                   close;
   logic                   accept;

   always_comb begin
      cls    = CLS_DATA;
      sextet = '0;
      case (req_in_char) inside
         [CHAR_UPPER_A:CHAR_UPPER_Z]: sextet = 6'(req_in_char - CHAR_UPPER_A);
         [CHAR_LOWER_A:CHAR_LOWER_Z]: sextet = 6'(req_in_char - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
         [CHAR_DIGIT_0:CHAR_DIGIT_9]: sextet = 6'(req_in_char - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
         CHAR_PLUS:                   sextet = SEXTET_PLUS;
         CHAR_SLASH:                  sextet = SEXTET_SLASH;
         CHAR_PAD:                    cls = CLS_PAD;
         default:                     cls = CLS_BAD;
      endcase
   end

   always_comb begin
      acc_in   = acc_ff;
      bits_in  = bits_ff;
      chars_in = chars_ff;
      bad_in   = bad_ff;
      close    = 1'b0;
      bits_sum = {1'b0, bits_ff} + (COUNT_WIDTH+1)'(6);
      case (cls)
         CLS_DATA: begin
            acc_in  = {acc_ff[ACC_WIDTH-7:0], sextet};
            bits_in = (bits_sum > {1'b0, MAX_BITS}) ? MAX_BITS : bits_sum[COUNT_WIDTH-1:0];
         end
         CLS_PAD: begin
            acc_in  = acc_ff >> 2;
            bits_in = (bits_ff >= COUNT_WIDTH'(2)) ? bits_ff - COUNT_WIDTH'(2) : '0;
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
      if (cls != CLS_BAD) begin
         close    = (chars_ff == 2'd3);
         chars_in = chars_ff + 2'd1;
      end
      if (req_in_last) begin
         close = 1'b1;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && close;

   assign push_data.acc       = acc_in;
   assign push_data.bit_count = bits_in;
   assign push_data.last      = req_in_last;
   assign push_data.bad       = bad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         bits_ff  <= '0;
         chars_ff <= '0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         if (close) begin
            acc_ff   <= '0;
            bits_ff  <= '0;
            chars_ff <= '0;
            bad_ff   <= 1'b0;
         end else begin
            acc_ff   <= acc_in;
            bits_ff  <= bits_in;
            chars_ff <= chars_in;
            bad_ff   <= bad_in;
         end
      end
   end

endmodule

/* hdl/b64d_fifo.sv */
// small group queue between front and back
module b64d_fifo
   import b64d_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   input  logic      pop,
   output group_type head,
   output logic      full,
   output logic      empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   group_type         mem [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("group pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

/* hdl/b64d_back.sv */
// back end: splits a queued group into byte results through an output register
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  group_type  head,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_stream_end,
   output logic       rsp_bad_char
);

   logic                   valid_ff;
   logic [1:0]             idx_ff;
   logic [7:0]             data_ff;
   logic                   byte_valid_ff, run_last_ff, stream_end_ff, bad_ff;
   logic                   load;
   logic [1:0]             nbytes;
   logic                   is_end;
   logic [COUNT_WIDTH-1:0] offset, shift;
   logic [ACC_WIDTH-1:0]   shifted;

   assign load   = !q_empty && (!valid_ff || rsp_ready);
   assign nbytes = head.bit_count[COUNT_WIDTH-1:3];
   assign is_end = (nbytes == 2'd0) || (idx_ff == nbytes - 2'd1);
   assign pop    = load && is_end;

   // byte k sits at bit_count - 8*(k+1)
   assign offset  = COUNT_WIDTH'({idx_ff, 3'b000}) + COUNT_WIDTH'(8);
   assign shift   = head.bit_count - offset;
   assign shifted = head.acc >> shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= is_end ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_valid_ff <= (nbytes != 2'd0);
         data_ff       <= (nbytes != 2'd0) ? shifted[7:0] : 8'd0;
         run_last_ff   <= is_end;
         stream_end_ff <= head.last;
         bad_ff        <= head.bad;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_stream_end = stream_end_ff;
   assign rsp_bad_char   = bad_ff;

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !byte_valid_ff) |-> (data_ff == 8'd0 && run_last_ff))
      else $error("result without byte must be zero and close the run");

   a_run_has_group: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !q_empty) else $error("run index open with empty queue");

endmodule
